>>> src/bbe_pkg.sv
// Shared types, widths and sequencer codes for the B-spline basis evaluator.
`timescale 1ns / 1ps
package bbe_pkg;

  localparam int KNOT_W  = 32;
  localparam int DEG_W   = 3;
  localparam int KCNT_W  = 7;
  localparam int PIDX_W  = 6;
  localparam int WGT_W   = 17;
  localparam int N_W     = 31;          // basis value, unsigned Q1.30, at most one
  localparam int DIFF_W  = 32;          // clamped knot distance
  localparam int PROD_W  = N_W + DIFF_W;
  localparam int DEN_W   = DIFF_W + 1;
  localparam int STEP_W  = 5;
  localparam logic [STEP_W-1:0] DIV_STEPS = 5'd31;
  localparam logic [N_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [N_W-1:0] HALF_LSB = 31'h0000_2000;
  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

  localparam logic [1:0] CFG_DEGREE     = 2'd0;
  localparam logic [1:0] CFG_KNOT_COUNT = 2'd1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_K0   = 4'd1;
  localparam logic [ST_W-1:0] ST_K1   = 4'd2;
  localparam logic [ST_W-1:0] ST_RDL  = 4'd3;
  localparam logic [ST_W-1:0] ST_RDR  = 4'd4;
  localparam logic [ST_W-1:0] ST_RDW  = 4'd5;
  localparam logic [ST_W-1:0] ST_MUL  = 4'd6;
  localparam logic [ST_W-1:0] ST_DIVS = 4'd7;
  localparam logic [ST_W-1:0] ST_DIVW = 4'd8;
  localparam logic [ST_W-1:0] ST_UPD  = 4'd9;
  localparam logic [ST_W-1:0] ST_OUT  = 4'd10;
  localparam logic [ST_W-1:0] ST_ERR  = 4'd11;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] quo;
    logic           rem_nz;
  } div_res_t;

endpackage

>>> src/bspline_basis_evaluator_top.sv
// Top level: command decode, Cox-de Boor sequencer, result output.
//
// Usage: raise start_i with func_i and the item fields while busy_o is low.
// A knot write (func_i low) stores knot_value_i at knot_index_i, gives no
// result and leaves busy_o low. An evaluation (func_i high) raises busy_o
// and later puts degree+1 results on the output ports, one a cycle, each
// marked by result_valid_o for one cycle; last_o marks the final one. A bad
// span gives one result with status_o high. The receiver cannot stall.
// Knot reads go one at a time through the single table read port; each of
// the degree*(degree+1)/2 recurrence terms takes one multiply, one divider
// start, 31 divider steps, a wait for the divider to finish and one update
// (the divider is skipped when the denominator is zero), and no new command
// is taken while an evaluation keeps busy_o high.
// Configuration writes on cfg_we_i take effect at once; index 0 is degree,
// index 1 knot_count. Reset sets degree to three and knot_count to zero;
// the knot table holds no defined value until written.
`timescale 1ns / 1ps
module bspline_basis_evaluator_top #(
  parameter int MAX_KNOTS = 64,
  parameter int MAX_ORDER = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        func_i,
  input  logic [5:0]                  knot_index_i,
  input  logic signed [bbe_pkg::KNOT_W-1:0] knot_value_i,
  input  logic [5:0]                  span_index_i,
  input  logic signed [bbe_pkg::KNOT_W-1:0] parameter_req_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [bbe_pkg::KCNT_W-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [bbe_pkg::WGT_W-1:0]   weight_o,
  output logic [bbe_pkg::PIDX_W-1:0]  ctrl_point_o,
  output logic                        status_o,
  output logic                        last_o
);
  import bbe_pkg::*;

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int IW = (AW + 2 > 8) ? AW + 2 : 8;

  logic [DEG_W-1:0]  degree_q;
  logic [KCNT_W-1:0] knot_count_q;

  logic [ST_W-1:0]   state_q, state_d;
  logic [PIDX_W-1:0] s_q;
  logic [DEG_W-1:0]  p_q, j_q, r_q, oj_q;
  logic signed [KNOT_W-1:0] u_q, k0_q;
  logic [N_W-1:0]    n_q [8];
  logic [DIFF_W-1:0] left_q [8];
  logic [DIFF_W-1:0] right_q [8];
  logic [N_W-1:0]    saved_q;
  logic [PROD_W-1:0] prod_q;
  logic [DEN_W-1:0]  den_q;
  logic              den_zero_q;

  logic              res_valid_q, res_status_q, res_last_q;
  logic [WGT_W-1:0]  res_weight_q;
  logic [PIDX_W-1:0] res_point_q;

  logic              accept;
  logic [IW-1:0]     s_w, cnt_w, reach_w, wr_idx_w, rd_idx;
  logic              span_bad;
  logic              ram_we;
  logic [KNOT_W-1:0] ram_rdata;
  logic signed [KNOT_W-1:0] knot_s;
  logic signed [KNOT_W:0]   dl, dr;
  logic signed [KNOT_W-1:0] u_clamp;
  div_res_t          div_res;
  logic              div_start;
  logic [N_W-1:0]    term_a, term_b, n_r;
  logic [N_W:0]      sum_a;
  logic [N_W-1:0]    round_sum;
  logic [DEG_W-1:0]  j_minus_r, r_plus1;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign knot_s = ram_rdata;

  // span checks on the incoming command
  always_comb begin
    s_w      = IW'(span_index_i);
    wr_idx_w = IW'(knot_index_i);
    cnt_w    = (IW'(knot_count_q) > IW'(MAX_KNOTS)) ? IW'(MAX_KNOTS) : IW'(knot_count_q);
    reach_w  = (degree_q == '0) ? IW'(1) : IW'(degree_q);
    span_bad = (s_w < IW'(degree_q)) || (s_w + reach_w >= cnt_w) ||
               (IW'(degree_q) + IW'(1) > IW'(MAX_ORDER));
    ram_we   = accept && (func_i == FUNC_WRITE) && (wr_idx_w < IW'(MAX_KNOTS));
  end

  // knot table read address for each sequencer step
  always_comb begin
    case (state_q)
      ST_IDLE: rd_idx = s_w;
      ST_K0:   rd_idx = IW'(s_q) + IW'(1);
      ST_RDL:  rd_idx = IW'(s_q) + IW'(1) - IW'(j_q);
      ST_RDR:  rd_idx = IW'(s_q) + IW'(j_q);
      default: rd_idx = IW'(s_q);
    endcase
  end

  bbe_knot_ram #(.DEPTH(MAX_KNOTS), .AW(AW)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_w[AW-1:0]),
    .wdata_i (knot_value_i),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign div_start = (state_q == ST_DIVS) && !den_zero_q;

  bbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  always_comb begin
    dl        = {u_q[KNOT_W-1], u_q} - {knot_s[KNOT_W-1], knot_s};
    dr        = {knot_s[KNOT_W-1], knot_s} - {u_q[KNOT_W-1], u_q};
    u_clamp   = (u_q < k0_q) ? k0_q : ((u_q > knot_s) ? knot_s : u_q);
    j_minus_r = j_q - r_q;
    r_plus1   = r_q + 1'b1;
    n_r       = n_q[r_q];
    // b follows from a: floor(N*l/d) = N - ceil(N*r/d)
    term_a    = den_zero_q ? '0 : div_res.quo;
    term_b    = den_zero_q ? '0 : (n_r - div_res.quo - N_W'(div_res.rem_nz));
    sum_a     = {1'b0, saved_q} + {1'b0, term_a};
    round_sum = n_q[oj_q] + HALF_LSB;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_EVAL)) begin
          state_d = span_bad ? ST_ERR : ST_K0;
        end
      end
      ST_K0:   state_d = ST_K1;
      ST_K1: begin
        if (knot_s <= k0_q) begin
          state_d = ST_ERR;
        end else if (p_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_RDL;
        end
      end
      ST_RDL:  state_d = ST_RDR;
      ST_RDR:  state_d = ST_RDW;
      ST_RDW:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIVS;
      ST_DIVS: state_d = den_zero_q ? ST_UPD : ST_DIVW;
      ST_DIVW: state_d = div_res.done ? ST_UPD : ST_DIVW;
      ST_UPD: begin
        if (r_plus1 != j_q) begin
          state_d = ST_MUL;
        end else if (j_q == p_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_RDL;
        end
      end
      ST_OUT:  state_d = (oj_q == p_q) ? ST_IDLE : ST_OUT;
      ST_ERR:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      degree_q     <= DEG_W'(3);
      knot_count_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_OUT) || (state_q == ST_ERR);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEGREE:     degree_q     <= cfg_wdata_i[DEG_W-1:0];
          CFG_KNOT_COUNT: knot_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        s_q  <= span_index_i;
        p_q  <= degree_q;
        u_q  <= parameter_req_i;
        oj_q <= '0;
      end
      ST_K0: k0_q <= knot_s;
      ST_K1: begin
        u_q    <= u_clamp;
        n_q[0] <= ONE_Q30;
        j_q    <= DEG_W'(1);
      end
      ST_RDR: left_q[j_q]  <= dl[KNOT_W] ? '0 : dl[DIFF_W-1:0];
      ST_RDW: begin
        right_q[j_q] <= dr[KNOT_W] ? '0 : dr[DIFF_W-1:0];
        r_q          <= '0;
        saved_q      <= '0;
      end
      ST_MUL: begin
        prod_q     <= PROD_W'(n_r) * PROD_W'(right_q[r_plus1]);
        den_q      <= DEN_W'(right_q[r_plus1]) + DEN_W'(left_q[j_minus_r]);
        den_zero_q <= (right_q[r_plus1] == '0) && (left_q[j_minus_r] == '0);
      end
      ST_UPD: begin
        n_q[r_q] <= (sum_a > {1'b0, ONE_Q30}) ? ONE_Q30 : sum_a[N_W-1:0];
        saved_q  <= term_b;
        r_q      <= r_plus1;
        if (r_plus1 == j_q) begin
          n_q[j_q] <= (term_b > ONE_Q30) ? ONE_Q30 : term_b;
          j_q      <= j_q + 1'b1;
        end
      end
      default: ;
    endcase

    if (state_q == ST_OUT) begin
      res_weight_q <= (round_sum[N_W-1:14] > WGT_ONE) ? WGT_ONE : round_sum[N_W-1:14];
      res_point_q  <= s_q - PIDX_W'(p_q) + PIDX_W'(oj_q);
      res_status_q <= 1'b0;
      res_last_q   <= (oj_q == p_q);
      oj_q         <= oj_q + 1'b1;
    end else if (state_q == ST_ERR) begin
      res_weight_q <= '0;
      res_point_q  <= '0;
      res_status_q <= 1'b1;
      res_last_q   <= 1'b1;
    end
  end

  assign result_valid_o = res_valid_q;
  assign weight_o       = res_weight_q;
  assign ctrl_point_o   = res_point_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> last_o)
    else $error("error result without last");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result transfer straight after last");

  a_eval_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (func_i == FUNC_EVAL) |=> busy_o)
    else $error("evaluation accepted without going busy");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIVW))
    else $error("divider finished outside its wait step");
endmodule

>>> src/bbe_knot_ram.sv
// Knot table: single write port, one registered read port.
`timescale 1ns / 1ps
module bbe_knot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bbe_pkg::KNOT_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bbe_pkg::KNOT_W-1:0] rdata_o
);
  import bbe_pkg::*;

  logic [KNOT_W-1:0] mem [DEPTH];
  logic [KNOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/bbe_div.sv
// Restoring divider, one quotient bit a cycle; quotient known to fit N_W bits.
`timescale 1ns / 1ps
module bbe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bbe_pkg::PROD_W-1:0] num_i,
  input  logic [bbe_pkg::DEN_W-1:0]  den_i,
  output bbe_pkg::div_res_t          res_o
);
  import bbe_pkg::*;

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [N_W-1:0]    low_q;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic              qbit;

  always_comb begin
    trial = {rem_q, low_q[N_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_STEPS;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[PROD_W-1:N_W]};
      low_q <= num_i[N_W-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      low_q <= {low_q[N_W-2:0], qbit};
    end
  end

  assign res_o.done   = done_q;
  assign res_o.quo    = low_q;
  assign res_o.rem_nz = (rem_q != '0);
endmodule
